FILE: rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants of the pedal plausibility and torque map block.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int TIME_W     = 32;
    localparam int ADC_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int PERIOD_W   = 16;
    localparam int LIMIT_W    = 10;
    localparam int MAXT_W     = 15;
    localparam int TORQUE_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // serial divider operand widths
    localparam int DIV_NUM_W = ADC_W + MAXT_W;
    localparam int DIV_DEN_W = ADC_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CH2_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_FAULT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TORQUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_TORQUE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_FAULT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE    = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [ADC_W-1:0]  adc_1;
        logic [ADC_W-1:0]  adc_2;
    } in_t;

    typedef struct packed {
        logic                       sampled;
        logic [ADC_W-1:0]           filtered_1;
        logic [ADC_W-1:0]           filtered_2;
        logic                       mismatch;
        logic                       persistent_fault;
        logic                       range_fault;
        logic signed [TORQUE_W-1:0] torque;
    } out_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] sample_period_ms;
        logic [GAIN_W-1:0]   ch2_gain_q8;
        logic [LIMIT_W-1:0]  mismatch_limit;
        logic [LIMIT_W-1:0]  lower_fault_limit;
        logic [LIMIT_W-1:0]  zero_torque_limit;
        logic [LIMIT_W-1:0]  full_torque_limit;
        logic [LIMIT_W-1:0]  upper_fault_limit;
        logic [MAXT_W-1:0]   max_torque;
    } cfg_t;

    typedef struct packed {
        logic [ADC_W-1:0] s1;
        logic [ADC_W-1:0] s2;
    } ring_word_t;

endpackage

FILE: rtl/ppt_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppt_cfg_regs
// Configuration register file, write-only, decoded by register index.
// ----------------------------------------------------------------------------
module ppt_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ppt_pkg::cfg_t                    cfg
);
    import ppt_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_period_ms  <= PERIOD_W'(1);
            cfg_reg.ch2_gain_q8       <= GAIN_W'(256);
            cfg_reg.mismatch_limit    <= LIMIT_W'(102);
            cfg_reg.lower_fault_limit <= LIMIT_W'(0);
            cfg_reg.zero_torque_limit <= LIMIT_W'(0);
            cfg_reg.full_torque_limit <= LIMIT_W'(1023);
            cfg_reg.upper_fault_limit <= LIMIT_W'(1023);
            cfg_reg.max_torque        <= MAXT_W'(32767);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SAMPLE_PERIOD: cfg_reg.sample_period_ms  <= cfg_data[PERIOD_W-1:0];
                REG_CH2_GAIN:      cfg_reg.ch2_gain_q8       <= cfg_data[GAIN_W-1:0];
                REG_MISMATCH:      cfg_reg.mismatch_limit    <= cfg_data[LIMIT_W-1:0];
                REG_LOWER_FAULT:   cfg_reg.lower_fault_limit <= cfg_data[LIMIT_W-1:0];
                REG_ZERO_TORQUE:   cfg_reg.zero_torque_limit <= cfg_data[LIMIT_W-1:0];
                REG_FULL_TORQUE:   cfg_reg.full_torque_limit <= cfg_data[LIMIT_W-1:0];
                REG_UPPER_FAULT:   cfg_reg.upper_fault_limit <= cfg_data[LIMIT_W-1:0];
                REG_MAX_TORQUE:    cfg_reg.max_torque        <= cfg_data[MAXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/ppt_ring_mem.sv
// ----------------------------------------------------------------------------
// ppt_ring_mem
// Averaging ring storage for both channels: one write port, one registered
// read port, per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module ppt_ring_mem #(
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [AW-1:0]       rd_addr,
    output ppt_pkg::ring_word_t rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  ppt_pkg::ring_word_t wr_data
);
    import ppt_pkg::*;

    ring_word_t mem [DEPTH];
    logic       valid_reg [DEPTH];
    ring_word_t rd_data_reg;
    logic       rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: rtl/ppt_div.sv
// ----------------------------------------------------------------------------
// ppt_div
// Restoring serial divider, one quotient bit per cycle. Scales the torque
// over the linear pedal band.
// ----------------------------------------------------------------------------
module ppt_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ppt_pkg::DIV_NUM_W-1:0]  dividend,
    input  logic [ppt_pkg::DIV_DEN_W-1:0]  divisor,
    output logic                           done,
    output logic [ppt_pkg::DIV_NUM_W-1:0]  quotient
);
    import ppt_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            rem_reg <= fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/pedal_plausibility_torque_map.sv
// ----------------------------------------------------------------------------
// pedal_plausibility_torque_map
// Dual pedal sensor averaging, plausibility fault timing and torque map.
//
//   channel  direction  ports                     content
//   s_       in         s_valid s_ready s_data    timestamp, two ADC samples
//   m_       out        m_valid m_ready m_data    averages, flags, torque
//   cfg_     in         cfg_we cfg_index cfg_data register writes
//
// One item at a time: check, update, multiply, fault, map and done states,
// plus an averaging state on a sampled item for the reciprocal-multiply
// averages, and start and wait states when the pedal lies in the linear band,
// where the serial divider (25 steps) scales the torque.
// Reset clears the ring valid bits at once; no clearing pass.
// A result waits in the output register; the next item is taken meanwhile,
// and only finishing it stalls on a full output register.
// ----------------------------------------------------------------------------
module pedal_plausibility_torque_map #(
    parameter int AVG_DEPTH      = 16,
    parameter int FAULT_HOLD_MS  = 100,
    parameter int IDLE_TORQUE    = 0,
    parameter int FLIP_DIRECTION = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ppt_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ppt_pkg::out_t                   m_data,
    input  logic                            cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ppt_pkg::*;

    localparam int AW         = $clog2(AVG_DEPTH);
    localparam int SUM_W      = ADC_W + AW;
    localparam int SUM_MAX    = ((1 << ADC_W) - 1) * AVG_DEPTH;
    localparam int GPROD_W    = ADC_W + GAIN_W;
    // rounded average (2*sum + depth) / (2*depth) as an exact reciprocal multiply
    localparam int AVG_NUM_W  = SUM_W + 1;
    localparam int AVG_DIV    = 2 * AVG_DEPTH;
    localparam int AVG_SHIFT  = AVG_NUM_W + $clog2(AVG_DIV);
    localparam int RECIP_W    = AVG_NUM_W + 1;
    localparam int AVG_PROD_W = AVG_NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_DIV) - 64'd1) / 64'(AVG_DIV));

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_UPDATE,
        S_AVG,
        S_MULT,
        S_FAULT,
        S_MAP,
        S_TQ_GO,
        S_TQ_WAIT,
        S_DONE
    } state_t;

    state_t                state_reg;
    cfg_t                  cfg;
    in_t                   in_reg;
    logic                  sampled_reg;
    logic [SUM_W-1:0]      sum1_reg;
    logic [SUM_W-1:0]      sum2_reg;
    logic [AW-1:0]         ptr_reg;
    logic [TIME_W-1:0]     last_reg;
    logic                  fault_active_reg;
    logic [TIME_W-1:0]     fault_start_reg;
    logic [ADC_W-1:0]      pedal_reg;
    logic [ADC_W-1:0]      f1_reg;
    logic [ADC_W-1:0]      f2_reg;
    logic                  mis_reg;
    logic                  persist_reg;
    logic                  range_reg;
    logic [MAXT_W-1:0]     tq_mag_reg;
    logic                  out_valid_reg;
    out_t                  out_reg;
    logic [GPROD_W-1:0]    gain_prod_reg;
    logic [DIV_NUM_W-1:0]  tq_prod_reg;

    ring_word_t            rd_word;
    ring_word_t            wr_word;
    logic                  mem_we;
    logic                  due;
    logic [SUM_W-1:0]      sum1_next;
    logic [SUM_W-1:0]      sum2_next;
    logic [AW-1:0]         ptr_next;
    logic [AVG_NUM_W-1:0]  avg1_num;
    logic [AVG_NUM_W-1:0]  avg2_num;
    logic [AVG_PROD_W-1:0] avg1_prod;
    logic [AVG_PROD_W-1:0] avg2_prod;
    logic                  div_start;
    logic                  div_done;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;
    logic [DIV_NUM_W-1:0]  div_quo;
    logic [GPROD_W-1:0]    f1_scaled;
    logic [GPROD_W-1:0]    diff_abs;
    logic                  mis_now;
    logic                  persist_now;
    logic [ADC_W-1:0]      lin_offset;
    logic signed [TORQUE_W-1:0] tq_pos;
    logic signed [TORQUE_W-1:0] tq_out;

    ppt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppt_ring_mem #(
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (ptr_reg),
        .rd_data (rd_word),
        .wr_en   (mem_we),
        .wr_addr (ptr_reg),
        .wr_data (wr_word)
    );

    ppt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign due       = (in_reg.now_ms - last_reg) > TIME_W'(cfg.sample_period_ms);
    assign sum1_next = sum1_reg - SUM_W'(rd_word.s1) + SUM_W'(in_reg.adc_1);
    assign sum2_next = sum2_reg - SUM_W'(rd_word.s2) + SUM_W'(in_reg.adc_2);
    assign ptr_next  = (ptr_reg == AW'(AVG_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign mem_we    = (state_reg == S_UPDATE) && sampled_reg;
    assign wr_word   = '{s1: in_reg.adc_1, s2: in_reg.adc_2};

    assign avg1_num  = {sum1_reg, 1'b0} + AVG_NUM_W'(AVG_DEPTH);
    assign avg2_num  = {sum2_reg, 1'b0} + AVG_NUM_W'(AVG_DEPTH);
    assign avg1_prod = AVG_PROD_W'(avg1_num) * AVG_PROD_W'(AVG_RECIP);
    assign avg2_prod = AVG_PROD_W'(avg2_num) * AVG_PROD_W'(AVG_RECIP);

    assign div_start = (state_reg == S_TQ_GO);
    assign div_num   = tq_prod_reg;
    assign div_den   = cfg.full_torque_limit - cfg.zero_torque_limit;

    // |f1*256 - f2*gain| > limit*256
    assign f1_scaled = GPROD_W'({f1_reg, 8'h00});
    assign diff_abs  = (f1_scaled > gain_prod_reg) ? f1_scaled - gain_prod_reg
                                                   : gain_prod_reg - f1_scaled;
    assign mis_now   = diff_abs > GPROD_W'({cfg.mismatch_limit, 8'h00});

    assign persist_now = fault_active_reg &&
                         ((in_reg.now_ms - fault_start_reg) > TIME_W'(FAULT_HOLD_MS));

    assign lin_offset = pedal_reg - cfg.zero_torque_limit;

    assign tq_pos = $signed({1'b0, tq_mag_reg});
    assign tq_out = (FLIP_DIRECTION != 0) ? -tq_pos : tq_pos;

    always_ff @(posedge aclk) begin
        if ((state_reg == S_IDLE) && s_valid) begin
            in_reg <= s_data;
        end
        if (state_reg == S_MULT) begin
            gain_prod_reg <= GPROD_W'(f2_reg) * GPROD_W'(cfg.ch2_gain_q8);
        end
        if (state_reg == S_MAP) begin
            tq_prod_reg <= DIV_NUM_W'(lin_offset) * DIV_NUM_W'(cfg.max_torque);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            sampled_reg      <= 1'b0;
            sum1_reg         <= '0;
            sum2_reg         <= '0;
            ptr_reg          <= '0;
            last_reg         <= '0;
            fault_active_reg <= 1'b0;
            fault_start_reg  <= '0;
            pedal_reg        <= '0;
            f1_reg           <= '0;
            f2_reg           <= '0;
            mis_reg          <= 1'b0;
            persist_reg      <= 1'b0;
            range_reg        <= 1'b0;
            tq_mag_reg       <= '0;
            out_valid_reg    <= 1'b0;
            out_reg          <= '0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    sampled_reg <= due;
                    state_reg   <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (sampled_reg) begin
                        sum1_reg  <= sum1_next;
                        sum2_reg  <= sum2_next;
                        ptr_reg   <= ptr_next;
                        last_reg  <= in_reg.now_ms;
                        state_reg <= S_AVG;
                    end else begin
                        state_reg <= S_MULT;
                    end
                end
                S_AVG: begin
                    f1_reg    <= avg1_prod[AVG_SHIFT +: ADC_W];
                    f2_reg    <= avg2_prod[AVG_SHIFT +: ADC_W];
                    state_reg <= S_MULT;
                end
                S_MULT: state_reg <= S_FAULT;
                S_FAULT: begin
                    mis_reg <= mis_now;
                    if (sampled_reg) begin
                        pedal_reg <= f1_reg;
                        if (mis_now) begin
                            if (!fault_active_reg) begin
                                fault_active_reg <= 1'b1;
                                fault_start_reg  <= in_reg.now_ms;
                            end
                        end else begin
                            fault_active_reg <= 1'b0;
                        end
                    end
                    state_reg <= S_MAP;
                end
                S_MAP: begin
                    persist_reg <= persist_now;
                    range_reg   <= 1'b0;
                    state_reg   <= S_DONE;
                    if (pedal_reg < cfg.lower_fault_limit) begin
                        range_reg  <= 1'b1;
                        tq_mag_reg <= '0;
                    end else if (pedal_reg < cfg.zero_torque_limit) begin
                        tq_mag_reg <= MAXT_W'(IDLE_TORQUE);
                    end else if (pedal_reg < cfg.full_torque_limit) begin
                        state_reg <= S_TQ_GO;
                    end else if (pedal_reg < cfg.upper_fault_limit) begin
                        tq_mag_reg <= cfg.max_torque;
                    end else begin
                        range_reg  <= 1'b1;
                        tq_mag_reg <= '0;
                    end
                end
                S_TQ_GO: state_reg <= S_TQ_WAIT;
                S_TQ_WAIT: begin
                    if (div_done) begin
                        tq_mag_reg <= div_quo[MAXT_W-1:0];
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg            <= 1'b1;
                        out_reg.sampled          <= sampled_reg;
                        out_reg.filtered_1       <= f1_reg;
                        out_reg.filtered_2       <= f2_reg;
                        out_reg.mismatch         <= mis_reg;
                        out_reg.persistent_fault <= persist_reg;
                        out_reg.range_fault      <= range_reg;
                        out_reg.torque           <= tq_out;
                        state_reg                <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum1_reg <= SUM_W'(SUM_MAX)) && (sum2_reg <= SUM_W'(SUM_MAX)))
        else $error("ring sum out of range");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= AW'(AVG_DEPTH - 1))
        else $error("ring pointer beyond depth");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_TQ_WAIT))
        else $error("divider finished outside a wait state");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transfer taken while busy");

    a_persist_needs_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !fault_active_reg) |-> !persist_reg)
        else $error("persistent fault without active fault");

endmodule

FILE: test/tb_pedal_plausibility_torque_map.sv
// ----------------------------------------------------------------------------
// tb_pedal_plausibility_torque_map
// Self-checking bench for the pedal plausibility and torque map block. Items
// go in over the s_ channel and each one is predicted on its transfer: ring
// averages, Q8.8 plausibility compare, fault timer and torque bands. Every m_
// transfer is checked field by field against the oldest prediction. Register
// settings are swept between phases while the block is idle, and both sides
// stall in random bursts while idling is switched on.
// ----------------------------------------------------------------------------
module tb_pedal_plausibility_torque_map;
    import ppt_pkg::*;

    localparam int AVG_DEPTH      = 16;
    localparam int FAULT_HOLD_MS  = 100;
    localparam int IDLE_TORQUE    = 0;
    localparam int FLIP_DIRECTION = 0;
    localparam int SETTLE_CYCLES  = 120;
    localparam int STALL_LIMIT    = 5000;

    typedef enum int {
        SCENE_AGREE,
        SCENE_DISAGREE,
        SCENE_HOLD,
        SCENE_NOISE
    } pedal_scene_e;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    in_t                     s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b1;
    out_t                    m_data;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_SAMPLE_PERIOD;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    // pedal model state
    cfg_t                    pedal_cfg;
    logic [ADC_W-1:0]        ring_1 [AVG_DEPTH];
    logic [ADC_W-1:0]        ring_2 [AVG_DEPTH];
    int unsigned             ring_slot;
    int unsigned             sum_1;
    int unsigned             sum_2;
    logic [TIME_W-1:0]       last_sample_ms;
    logic                    fault_on;
    logic [TIME_W-1:0]       fault_since_ms;
    int unsigned             pedal_level;

    out_t                    pending_results [$];
    int                      failures     = 0;
    int                      quiet_cycles = 0;
    bit                      idling_now   = 1'b0;
    logic [TIME_W-1:0]       stamp_ms     = '0;
    pedal_scene_e            scene        = SCENE_NOISE;
    int                      scene_left   = 0;
    int                      level_1      = 0;
    int                      level_2      = 0;

    pedal_plausibility_torque_map #(
        .AVG_DEPTH     (AVG_DEPTH),
        .FAULT_HOLD_MS (FAULT_HOLD_MS),
        .IDLE_TORQUE   (IDLE_TORQUE),
        .FLIP_DIRECTION(FLIP_DIRECTION)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic void reset_pedal_model();
        pedal_cfg.sample_period_ms  = 16'd1;
        pedal_cfg.ch2_gain_q8       = 16'd256;
        pedal_cfg.mismatch_limit    = 10'd102;
        pedal_cfg.lower_fault_limit = 10'd0;
        pedal_cfg.zero_torque_limit = 10'd0;
        pedal_cfg.full_torque_limit = 10'd1023;
        pedal_cfg.upper_fault_limit = 10'd1023;
        pedal_cfg.max_torque        = 15'd32767;
        foreach (ring_1[i]) begin
            ring_1[i] = '0;
            ring_2[i] = '0;
        end
        ring_slot      = 0;
        sum_1          = 0;
        sum_2          = 0;
        last_sample_ms = '0;
        fault_on       = 1'b0;
        fault_since_ms = '0;
        pedal_level    = 0;
    endfunction

    function automatic out_t predict_pedal_result(in_t it);
        out_t               r;
        logic [TIME_W-1:0]  since_sample;
        logic [TIME_W-1:0]  since_fault;
        int unsigned        f1;
        int unsigned        f2;
        int unsigned        span;
        int unsigned        lin;
        longint             scaled_1;
        longint             scaled_2;
        longint             dev;
        logic               took;
        logic               differ;
        logic               in_fault_band;
        logic signed [TORQUE_W-1:0] tq;

        since_sample = it.now_ms - last_sample_ms;
        took = since_sample > TIME_W'(pedal_cfg.sample_period_ms);
        if (took) begin
            last_sample_ms   = it.now_ms;
            sum_1            = sum_1 - 32'(ring_1[ring_slot]) + 32'(it.adc_1);
            sum_2            = sum_2 - 32'(ring_2[ring_slot]) + 32'(it.adc_2);
            ring_1[ring_slot] = it.adc_1;
            ring_2[ring_slot] = it.adc_2;
            ring_slot        = (ring_slot + 1) % AVG_DEPTH;
        end

        f1 = (2 * sum_1 + AVG_DEPTH) / (2 * AVG_DEPTH);
        f2 = (2 * sum_2 + AVG_DEPTH) / (2 * AVG_DEPTH);
        scaled_1 = longint'(f1) * 256;
        scaled_2 = longint'(f2) * longint'(pedal_cfg.ch2_gain_q8);
        dev = (scaled_1 > scaled_2) ? scaled_1 - scaled_2 : scaled_2 - scaled_1;
        differ = dev > longint'(pedal_cfg.mismatch_limit) * 256;

        if (took) begin
            pedal_level = f1;
            if (differ) begin
                if (!fault_on) begin
                    fault_on       = 1'b1;
                    fault_since_ms = it.now_ms;
                end
            end else begin
                fault_on = 1'b0;
            end
        end
        since_fault = it.now_ms - fault_since_ms;

        in_fault_band = 1'b0;
        tq = '0;
        if (pedal_level < 32'(pedal_cfg.lower_fault_limit)) begin
            in_fault_band = 1'b1;
        end else if (pedal_level < 32'(pedal_cfg.zero_torque_limit)) begin
            tq = TORQUE_W'(IDLE_TORQUE);
        end else if (pedal_level < 32'(pedal_cfg.full_torque_limit)) begin
            span = 32'(pedal_cfg.full_torque_limit - pedal_cfg.zero_torque_limit);
            lin  = ((pedal_level - 32'(pedal_cfg.zero_torque_limit)) *
                    32'(pedal_cfg.max_torque)) / span;
            tq   = TORQUE_W'(lin);
        end else if (pedal_level < 32'(pedal_cfg.upper_fault_limit)) begin
            tq = TORQUE_W'(pedal_cfg.max_torque);
        end else begin
            in_fault_band = 1'b1;
        end
        if (FLIP_DIRECTION != 0)
            tq = -tq;

        r.sampled          = took;
        r.filtered_1       = ADC_W'(f1);
        r.filtered_2       = ADC_W'(f2);
        r.mismatch         = differ;
        r.persistent_fault = fault_on && (since_fault > TIME_W'(FAULT_HOLD_MS));
        r.range_fault      = in_fault_band;
        r.torque           = tq;
        return r;
    endfunction

    function automatic int clamp_count(int v);
        if (v < 0)
            return 0;
        if (v > 1023)
            return 1023;
        return v;
    endfunction

    // pedal level close to one of the band limits, so held values land on edges
    function automatic int near_limit();
        int base;
        case ($urandom_range(0, 3))
            0: base = int'(pedal_cfg.lower_fault_limit);
            1: base = int'(pedal_cfg.zero_torque_limit);
            2: base = int'(pedal_cfg.full_torque_limit);
            default: base = int'(pedal_cfg.upper_fault_limit);
        endcase
        return clamp_count(base + int'($urandom_range(0, 2)) - 1);
    endfunction

    // channel 2 count that the gain maps back onto channel 1
    function automatic int matched_channel_2(int a1);
        int gain;
        gain = int'(pedal_cfg.ch2_gain_q8);
        if (gain == 0)
            return int'($urandom_range(0, 1023));
        return clamp_count((a1 * 256 + gain / 2) / gain);
    endfunction

    task automatic send_sample(input logic [TIME_W-1:0] t, input int a1, input int a2);
        in_t it;
        it.now_ms = t;
        it.adc_1  = ADC_W'(a1);
        it.adc_2  = ADC_W'(a2);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_pedal_result(it));
        if (idling_now && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SAMPLE_PERIOD: pedal_cfg.sample_period_ms  = value;
            REG_CH2_GAIN:      pedal_cfg.ch2_gain_q8       = value;
            REG_MISMATCH:      pedal_cfg.mismatch_limit    = value[LIMIT_W-1:0];
            REG_LOWER_FAULT:   pedal_cfg.lower_fault_limit = value[LIMIT_W-1:0];
            REG_ZERO_TORQUE:   pedal_cfg.zero_torque_limit = value[LIMIT_W-1:0];
            REG_FULL_TORQUE:   pedal_cfg.full_torque_limit = value[LIMIT_W-1:0];
            REG_UPPER_FAULT:   pedal_cfg.upper_fault_limit = value[LIMIT_W-1:0];
            REG_MAX_TORQUE:    pedal_cfg.max_torque        = value[MAXT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // junk in the unused upper bits of the narrow registers
    task automatic apply_config(input cfg_t c);
        wait_until_idle();
        set_register(REG_SAMPLE_PERIOD, c.sample_period_ms);
        set_register(REG_CH2_GAIN, c.ch2_gain_q8);
        set_register(REG_MISMATCH, {6'($urandom), c.mismatch_limit});
        set_register(REG_LOWER_FAULT, {6'($urandom), c.lower_fault_limit});
        set_register(REG_ZERO_TORQUE, {6'($urandom), c.zero_torque_limit});
        set_register(REG_FULL_TORQUE, {6'($urandom), c.full_torque_limit});
        set_register(REG_UPPER_FAULT, {6'($urandom), c.upper_fault_limit});
        set_register(REG_MAX_TORQUE, {1'($urandom), c.max_torque});
    endtask

    task automatic run_items(input int count, input bit may_idle);
        int          a1;
        int          a2;
        int unsigned pick;
        int unsigned period;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                idling_now = may_idle && ($urandom_range(0, 3) != 0);
            if (scene_left == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    scene = SCENE_AGREE;
                else if (pick < 60)
                    scene = SCENE_DISAGREE;
                else if (pick < 85)
                    scene = SCENE_HOLD;
                else
                    scene = SCENE_NOISE;
                scene_left = $urandom_range(8, 48);
                level_1 = ($urandom_range(0, 1) == 0) ? near_limit()
                                                       : int'($urandom_range(0, 1023));
                level_2 = $urandom_range(0, 1023);
            end
            scene_left--;

            period = 32'(pedal_cfg.sample_period_ms);
            pick = $urandom_range(0, 99);
            if (pick < 72)
                stamp_ms += period + 1 + $urandom_range(0, 3);
            else if (pick < 86)
                stamp_ms += $urandom_range(0, period);
            else if (pick < 92)
                stamp_ms += period;
            else if (pick < 97)
                stamp_ms += $urandom;
            else
                stamp_ms = $urandom;

            case (scene)
                SCENE_AGREE: begin
                    level_1 = clamp_count(level_1 + int'($urandom_range(0, 40)) - 20);
                    a1 = level_1;
                    a2 = clamp_count(matched_channel_2(a1) + int'($urandom_range(0, 4)) - 2);
                end
                SCENE_DISAGREE: begin
                    a1 = level_1;
                    a2 = level_2;
                end
                SCENE_HOLD: begin
                    a1 = level_1;
                    a2 = matched_channel_2(level_1);
                end
                default: begin
                    a1 = $urandom_range(0, 1023);
                    a2 = $urandom_range(0, 1023);
                end
            endcase
            send_sample(stamp_ms, a1, a2);
        end
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        int   lim [$];
        case ($urandom_range(0, 9))
            0:       c.sample_period_ms = PERIOD_W'($urandom_range(0, 65535));
            1, 2, 3: c.sample_period_ms = PERIOD_W'($urandom_range(0, 200));
            default: c.sample_period_ms = PERIOD_W'($urandom_range(0, 20));
        endcase
        c.ch2_gain_q8 = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(192, 320));
        c.mismatch_limit = ($urandom_range(0, 1) == 0) ? 10'($urandom)
                                                        : 10'($urandom_range(20, 200));
        repeat (4) lim.push_back(int'($urandom_range(0, 1023)));
        if ($urandom_range(0, 3) != 0)
            lim.sort();
        c.lower_fault_limit = LIMIT_W'(lim[0]);
        c.zero_torque_limit = LIMIT_W'(lim[1]);
        c.full_torque_limit = (lim[2] == 0) ? LIMIT_W'(1) : LIMIT_W'(lim[2]);
        c.upper_fault_limit = LIMIT_W'(lim[3]);
        c.max_torque        = MAXT_W'($urandom_range(0, 32767));
        return c;
    endfunction

    // ---- tests ----

    task automatic test_directed_cases();
        idling_now = 1'b1;
        // same and equal-to-period timestamps: not sampled
        send_sample(32'd0, 0, 0);
        send_sample(32'd1, 1023, 1023);
        // full versus empty sensor: mismatch builds and turns persistent
        for (int k = 0; k < 6; k++)
            send_sample(32'd2 + 32'(40 * k), 1023, 0);
        send_sample(32'd203, 0, 1023);
        send_sample(32'd303, 0, 0);
        // wrap of the millisecond counter and a step backward
        send_sample(32'hFFFF_FFF0, 1023, 1023);
        send_sample(32'h0000_0004, 512, 512);
        send_sample(32'h0000_0003, 1, 1022);
        send_sample(32'h0000_0005, 1023, 0);
        send_sample(32'h8000_0000, 0, 1023);
        for (int k = 1; k <= 6; k++)
            send_sample(32'h8000_0000 + 32'(2 * k), 700, 700);
        stamp_ms = 32'h8000_0010;
    endtask

    task automatic test_register_extremes();
        apply_config('{sample_period_ms: 16'd0, ch2_gain_q8: 16'd256,
                       mismatch_limit: 10'd102, lower_fault_limit: 10'd50,
                       zero_torque_limit: 10'd100, full_torque_limit: 10'd900,
                       upper_fault_limit: 10'd1000, max_torque: 15'd32767});
        run_items(120, 1'b1);
        apply_config('{sample_period_ms: 16'd65535, ch2_gain_q8: 16'd65535,
                       mismatch_limit: 10'd0, lower_fault_limit: 10'd0,
                       zero_torque_limit: 10'd0, full_torque_limit: 10'd1,
                       upper_fault_limit: 10'd0, max_torque: 15'd32767});
        run_items(120, 1'b1);
        apply_config('{sample_period_ms: 16'd2, ch2_gain_q8: 16'd0,
                       mismatch_limit: 10'd1023, lower_fault_limit: 10'd1023,
                       zero_torque_limit: 10'd1023, full_torque_limit: 10'd1023,
                       upper_fault_limit: 10'd1023, max_torque: 15'd0});
        run_items(120, 1'b1);
        // limits in reverse order
        apply_config('{sample_period_ms: 16'd3, ch2_gain_q8: 16'd128,
                       mismatch_limit: 10'd50, lower_fault_limit: 10'd600,
                       zero_torque_limit: 10'd300, full_torque_limit: 10'd200,
                       upper_fault_limit: 10'd100, max_torque: 15'd12345});
        run_items(120, 1'b1);
    endtask

    task automatic test_random_settings();
        repeat (6) begin
            apply_config(random_config());
            run_items(120, 1'b1);
        end
    endtask

    task automatic test_no_idling();
        apply_config('{sample_period_ms: 16'd1, ch2_gain_q8: 16'd256,
                       mismatch_limit: 10'd102, lower_fault_limit: 10'd30,
                       zero_torque_limit: 10'd80, full_torque_limit: 10'd950,
                       upper_fault_limit: 10'd1000, max_torque: 15'd30000});
        run_items(330, 1'b0);
    endtask

    // ---- result side ----

    initial begin
        forever begin
            @(posedge aclk);
            if (idling_now && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, m_data);
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("sampled", want.sampled, m_data.sampled);
                check_field("filtered_1", want.filtered_1, m_data.filtered_1);
                check_field("filtered_2", want.filtered_2, m_data.filtered_2);
                check_field("mismatch", want.mismatch, m_data.mismatch);
                check_field("persistent_fault", want.persistent_fault,
                            m_data.persistent_fault);
                check_field("range_fault", want.range_fault, m_data.range_fault);
                check_field("torque", want.torque, m_data.torque);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** pedal_plausibility_torque_map: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        reset_pedal_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_register_extremes();
        test_random_settings();
        test_no_idling();
        wait_until_idle();
        if (failures == 0)
            $display("** pedal_plausibility_torque_map: PASSED **");
        else
            $display("** pedal_plausibility_torque_map: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/ppt_pkg.sv
rtl/ppt_cfg_regs.sv
rtl/ppt_ring_mem.sv
rtl/ppt_div.sv
rtl/pedal_plausibility_torque_map.sv
test/tb_pedal_plausibility_torque_map.sv
